// File: design/ets_pkg.sv
`timescale 1ns / 1ps

package ets_pkg;

  // field widths
  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 4;
  localparam int TIME_W     = 32;
  localparam int WEIGHT_W   = 16;
  localparam int FRAC_BITS  = 8;
  localparam int ELAPSED_W  = 24;
  localparam int ACC_W      = 48;
  localparam int QUOT_W     = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // constants of the arithmetic
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = '1;
  localparam logic [TIME_W-1:0]    PERIOD_RESET = 32'd341333;
  localparam logic [WEIGHT_W-1:0]  DECAY_RESET  = 16'd65208;
  localparam logic [WEIGHT_W-1:0]  LIMIT_RESET  = 16'd64225;
  localparam logic [WEIGHT_W:0]    WEIGHT_ONE   = 17'd65536;
  localparam logic [ACC_W-1:0]     ROUND_HALF   = 48'd32768;
  localparam logic [QUOT_W-1:0]    LOAD_SAT     = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FRAME = 2'd0,
    ACT_LAP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic {
    REG_DECAY = 1'b0,
    REG_LIMIT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] decay_factor;
    logic [WEIGHT_W-1:0] load_limit;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  timer_index;
    logic [TIME_W-1:0]   now_us;
  } item_t;

  typedef struct packed {
    logic                index_valid;
    logic [TIME_W-1:0]   average_time;
    logic [TIME_W-1:0]   peak_time;
    logic [TIME_W-1:0]   max_time;
    logic [TIME_W-1:0]   frame_period;
    logic [QUOT_W-1:0]   cpu_load;
    logic                load_ok;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mul_old;
    logic mul_sample;
    logic mul_peak;
    logic write;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic load_sat;
  } status_t;

endpackage

// File: design/ets_in_if.sv
`timescale 1ns / 1ps

interface ets_in_if
  import ets_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  timer_index;
  logic [TIME_W-1:0]   now_us;

  modport source (output valid, action, timer_index, now_us, input ready);
  modport sink   (input valid, action, timer_index, now_us, output ready);
endinterface

// File: design/ets_out_if.sv
`timescale 1ns / 1ps

interface ets_out_if
  import ets_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              index_valid;
  logic [TIME_W-1:0] average_time;
  logic [TIME_W-1:0] peak_time;
  logic [TIME_W-1:0] max_time;
  logic [TIME_W-1:0] frame_period;
  logic [QUOT_W-1:0] cpu_load;
  logic              load_ok;

  modport source (output valid, index_valid, average_time, peak_time, max_time,
                  frame_period, cpu_load, load_ok, input ready);
  modport sink   (input valid, index_valid, average_time, peak_time, max_time,
                  frame_period, cpu_load, load_ok, output ready);
endinterface

// File: design/ets_cfg.sv
`timescale 1ns / 1ps

module ets_cfg
  import ets_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_index_t reg_sel;

  assign reg_sel = reg_index_t'(paddr[2]);
  assign pready  = 1'b1;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_factor <= DECAY_RESET;
      cfg.load_limit   <= LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_DECAY: cfg.decay_factor <= pwdata[WEIGHT_W-1:0];
        REG_LIMIT: cfg.load_limit   <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_DECAY: prdata = {{(CFG_DATA_W-WEIGHT_W){1'b0}}, cfg.decay_factor};
      REG_LIMIT: prdata = {{(CFG_DATA_W-WEIGHT_W){1'b0}}, cfg.load_limit};
      default:   prdata = '0;
    endcase
  end

endmodule

// File: design/ets_ctrl.sv
`timescale 1ns / 1ps

module ets_ctrl
  import ets_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int CNT_W = $clog2(QUOT_W);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL1   = 8'b0000_0010,
    S_MUL2   = 8'b0000_0100,
    S_MUL3   = 8'b0000_1000,
    S_WRITE  = 8'b0001_0000,
    S_DSTART = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] step;
  logic             last_step;
  logic             out_free;

  assign in_ready  = (state == S_IDLE);
  assign last_step = (step == CNT_W'(QUOT_W - 1));
  assign out_free  = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_MUL1;
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_MUL3;
      S_MUL3:   state_next = S_WRITE;
      S_WRITE:  state_next = S_DSTART;
      S_DSTART: state_next = status.load_sat ? S_DONE : S_DIV;
      S_DIV:    if (last_step) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == S_IDLE) && in_valid;
    cmd.mul_old    = (state == S_MUL1);
    cmd.mul_sample = (state == S_MUL2);
    cmd.mul_peak   = (state == S_MUL3);
    cmd.write      = (state == S_WRITE);
    cmd.div_start  = (state == S_DSTART);
    cmd.div_step   = (state == S_DIV);
    cmd.load_out   = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // division step count
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == S_DIV) begin
      step <= step + 1'b1;
    end else begin
      step <= '0;
    end
  end

  // result beat held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: design/ets_dp.sv
`timescale 1ns / 1ps

module ets_dp
  import ets_pkg::*;
#(
  parameter int TIMER_SLOTS = 8,
  parameter int TOTAL_SLOT  = 7
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  cfg_t    cfg,
  input  item_t   item,
  output status_t status,
  output res_t    res
);

  localparam int IDX_W = $clog2(TIMER_SLOTS);

  // statistics stores and frame state
  logic [TIME_W-1:0] avg_store  [TIMER_SLOTS];
  logic [TIME_W-1:0] peak_store [TIMER_SLOTS];
  logic [TIME_W-1:0] max_store  [TIMER_SLOTS];
  logic [TIME_W-1:0] frame_start;
  logic              frame_seen;
  logic [TIME_W-1:0] period_avg;

  // captured item
  action_t           act_q;
  logic              valid_q;
  logic [IDX_W-1:0]  slot_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] sample_q;
  logic [TIME_W-1:0] old_a;
  logic [TIME_W-1:0] old_p;
  logic [TIME_W-1:0] old_m;

  // arithmetic
  logic [WEIGHT_W:0]   mul_a;
  logic [TIME_W-1:0]   mul_b;
  logic [ACC_W:0]      mul_full;
  logic [ACC_W-1:0]    prod;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    peak_sum;
  logic [TIME_W-1:0]   new_avg;
  logic [TIME_W-1:0]   peak_dec;
  logic [TIME_W-1:0]   new_peak;
  logic [TIME_W-1:0]   new_max;

  // load division
  logic [TIME_W-1:0] total_peak;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] den;
  logic [QUOT_W-1:0] quo;
  logic              sat_q;
  logic              sat_now;
  logic [TIME_W:0]   rem2;
  logic [TIME_W:0]   rem_diff;
  logic              rem_ge;
  logic [QUOT_W-1:0] load;

  // incoming beat decode
  logic              idx_ok;
  logic [IDX_W-1:0]  slot_in;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] sample_in;

  assign idx_ok  = {1'b0, item.timer_index} < (INDEX_W + 1)'(TIMER_SLOTS);
  assign slot_in = item.timer_index[IDX_W-1:0];
  assign elapsed = item.now_us - frame_start;
  assign sample_in = (elapsed[TIME_W-1:ELAPSED_W] != '0)
                   ? {ELAPSED_MAX, {FRAC_BITS{1'b0}}}
                   : {elapsed[ELAPSED_W-1:0], {FRAC_BITS{1'b0}}};

  // capture the beat with its sample and old values
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q    <= action_t'(item.action);
      valid_q  <= idx_ok;
      slot_q   <= slot_in;
      now_q    <= item.now_us;
      sample_q <= sample_in;
      if (action_t'(item.action) == ACT_FRAME) begin
        old_a <= period_avg;
      end else begin
        old_a <= idx_ok ? avg_store[slot_in] : '0;
      end
      old_p <= idx_ok ? peak_store[slot_in] : '0;
      old_m <= idx_ok ? max_store[slot_in] : '0;
    end
  end

  // shared multiplier, one product a cycle
  always_comb begin
    mul_a = {1'b0, cfg.decay_factor};
    mul_b = old_a;
    if (cmd.mul_sample) begin
      mul_a = WEIGHT_ONE - {1'b0, cfg.decay_factor};
      mul_b = sample_q;
    end else if (cmd.mul_peak) begin
      mul_b = old_p;
    end
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_old || cmd.mul_sample || cmd.mul_peak) begin
      prod <= mul_full[ACC_W-1:0];
    end
    if (cmd.mul_sample) begin
      acc <= prod + ROUND_HALF;
    end else if (cmd.mul_peak) begin
      acc <= acc + prod;
    end
  end

  // new statistics
  assign new_avg  = acc[ACC_W-1:WEIGHT_W];
  assign peak_sum = prod + ROUND_HALF;
  assign peak_dec = peak_sum[ACC_W-1:WEIGHT_W];
  assign new_peak = (sample_q > peak_dec) ? sample_q : peak_dec;
  assign new_max  = (sample_q > old_m) ? sample_q : old_m;

  // store updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        avg_store[i]  <= '0;
        peak_store[i] <= '0;
        max_store[i]  <= '0;
      end
      frame_start <= '0;
      frame_seen  <= 1'b0;
      period_avg  <= PERIOD_RESET;
    end else if (cmd.write) begin
      unique case (act_q)
        ACT_FRAME: begin
          if (frame_seen) begin
            period_avg <= new_avg;
          end
          frame_start <= now_q;
          frame_seen  <= 1'b1;
        end
        ACT_LAP: begin
          if (valid_q) begin
            avg_store[slot_q]  <= new_avg;
            peak_store[slot_q] <= new_peak;
            max_store[slot_q]  <= new_max;
          end
        end
        ACT_CLEAR: begin
          if (valid_q) begin
            avg_store[slot_q]  <= '0;
            peak_store[slot_q] <= '0;
            max_store[slot_q]  <= '0;
          end
        end
        ACT_READ: ;
        default: ;
      endcase
    end
  end

  // peak of the total slot, zero when that slot does not exist
  generate
    if (TOTAL_SLOT < TIMER_SLOTS) begin : g_total
      assign total_peak = peak_store[IDX_W'(TOTAL_SLOT)];
    end else begin : g_no_total
      assign total_peak = '0;
    end
  endgenerate

  // load saturates when the quotient would not fit or the period is zero
  assign sat_now         = (period_avg == '0) || (total_peak >= period_avg);
  assign status.load_sat = sat_now;

  // restoring division, one quotient bit a cycle
  assign rem2     = {rem, 1'b0};
  assign rem_diff = rem2 - {1'b0, den};
  assign rem_ge   = (rem2 >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem   <= total_peak;
      den   <= period_avg;
      quo   <= '0;
      sat_q <= sat_now;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_diff[TIME_W-1:0] : rem2[TIME_W-1:0];
      quo <= {quo[QUOT_W-2:0], rem_ge};
    end
  end

  assign load = sat_q ? LOAD_SAT : quo;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.index_valid  <= valid_q;
      res.average_time <= valid_q ? avg_store[slot_q]  : '0;
      res.peak_time    <= valid_q ? peak_store[slot_q] : '0;
      res.max_time     <= valid_q ? max_store[slot_q]  : '0;
      res.frame_period <= period_avg;
      res.cpu_load     <= load;
      res.load_ok      <= (load < cfg.load_limit);
    end
  end

endmodule

// File: design/execution_time_statistics.sv
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// item      in   valid/ready    action, timer_index, now_us
// result    out  valid/ready    index_valid, average_time, peak_time, max_time,
//                               frame_period, cpu_load, load_ok
// apb       in   psel/penable   decay_factor at 0x0, load_limit at 0x4
//
// one item at a time: three multiply states, write, division start, division
// and result state; the division is skipped when the load saturates. the shared
// 17x32 multiplier takes three products, division one quotient bit per cycle.
// reset is synchronous; stores clear at once, no clearing pass.
// a finished result waits in the output register while the next item is taken.

module execution_time_statistics
  import ets_pkg::*;
#(
  parameter int TIMER_SLOTS = 8,
  parameter int TOTAL_SLOT  = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  ets_in_if.sink                item,
  ets_out_if.source             result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  item_t   item_data;
  res_t    res;

  assign item_data.action      = item.action;
  assign item_data.timer_index = item.timer_index;
  assign item_data.now_us      = item.now_us;

  // configuration registers
  ets_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  ets_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // stores and arithmetic
  ets_dp #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .TOTAL_SLOT  (TOTAL_SLOT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .item   (item_data),
    .status (status),
    .res    (res)
  );

  // result beat payload
  assign result.index_valid  = res.index_valid;
  assign result.average_time = res.average_time;
  assign result.peak_time    = res.peak_time;
  assign result.max_time     = res.max_time;
  assign result.frame_period = res.frame_period;
  assign result.cpu_load     = res.cpu_load;
  assign result.load_ok      = res.load_ok;

`ifndef NO_ASSERTIONS
  // one item at a time: no beat is taken right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item accepted while previous item in progress");

  // an out-of-range timer gives zero statistics
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.index_valid |->
      (result.average_time == '0 && result.peak_time == '0 && result.max_time == '0))
    else $error("statistics not zero for invalid timer");

  // average and decaying peak never exceed the running maximum
  a_max_bounds: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.index_valid |->
      (result.peak_time <= result.max_time && result.average_time <= result.max_time))
    else $error("average or peak above maximum");
`endif

endmodule
